>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every clock edge outside reset.
`define PHC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property failed");

// Checks that a signal keeps its value in the cycle after a condition.
`define PHC_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("%m: value changed while held");

`endif

>>> design/phc_pkg.sv
package phc_pkg;

  // Field and arithmetic widths.
  localparam int unsigned PixW       = 8;
  localparam int unsigned ClassW     = 3;
  localparam int unsigned RangeW     = 48;
  localparam int unsigned NumClasses = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned SatQW      = 8;
  localparam int unsigned SatRemW    = 16;
  localparam int unsigned HueQW      = 5;
  localparam int unsigned HueRemW    = 13;

  // Range reset: every min is 255 and every max is 0, so nothing matches.
  localparam logic [RangeW-1:0] RangeReset = 48'h00FF00FF00FF;

  // Hue constants on the two-degree scale (180 is a full turn).
  localparam logic [PixW-1:0] HueGreenBase = 8'd60;
  localparam logic [PixW-1:0] HueBlueBase  = 8'd120;
  localparam logic [PixW-1:0] HueWrap      = 8'd180;
  localparam logic [PixW-1:0] HueFoldMax   = 8'd160;
  localparam logic [PixW-1:0] HueFoldA     = 8'd162;
  localparam logic [PixW-1:0] HueFoldB     = 8'd171;
  localparam logic [PixW-1:0] HueFoldValA  = 8'd3;
  localparam logic [PixW-1:0] HueFoldValB  = 8'd2;
  localparam logic [PixW-1:0] HueFoldValC  = 8'd1;

  typedef enum logic [1:0] {
    HueBaseRed,
    HueBaseGreen,
    HueBaseBlue
  } hue_base_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLine     = 2'd0,
    CfgField    = 2'd1,
    CfgObstacle = 2'd2,
    CfgBall     = 2'd3
  } cfg_idx_e;

  typedef enum logic [ClassW-1:0] {
    ClassNone     = 3'd0,
    ClassLine     = 3'd1,
    ClassField    = 3'd2,
    ClassObstacle = 3'd3,
    ClassBall     = 3'd4
  } colour_class_e;

  // Item state carried through the divider stages.
  typedef struct packed {
    logic                 masked;
    logic [PixW-1:0]      mx;
    logic [PixW-1:0]      delta;
    hue_base_e            base;
    logic                 hue_neg;
    logic [SatRemW-1:0]   sat_rem;
    logic [SatQW-1:0]     sat_q;
    logic [HueRemW-1:0]   hue_rem;
    logic [HueQW-1:0]     hue_q;
  } div_t;

  // Finished HSV of one item before classification.
  typedef struct packed {
    logic            masked;
    logic [PixW-1:0] hue;
    logic [PixW-1:0] sat;
    logic [PixW-1:0] val;
  } hsv_t;

  // Inclusive bound test against one packed range word.
  function automatic logic in_range(logic [RangeW-1:0] rng, logic [PixW-1:0] h,
                                    logic [PixW-1:0] s, logic [PixW-1:0] v);
    return (h >= rng[7:0])   && (h <= rng[15:8]) &&
           (s >= rng[23:16]) && (s <= rng[31:24]) &&
           (v >= rng[39:32]) && (v <= rng[47:40]);
  endfunction

endpackage

>>> design/phc_if.sv
// Pixel input channel.
interface phc_pix_if;
  import phc_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] red;
  logic [PixW-1:0] green;
  logic [PixW-1:0] blue;
  logic            masked;
  modport source (output valid, red, green, blue, masked, input ready);
  modport sink (input valid, red, green, blue, masked, output ready);
endinterface

// Result output channel.
interface phc_res_if;
  import phc_pkg::*;
  logic              valid;
  logic              ready;
  logic [PixW-1:0]   hue;
  logic [PixW-1:0]   saturation;
  logic [PixW-1:0]   brightness;
  logic [ClassW-1:0] colour_class;
  modport source (output valid, hue, saturation, brightness, colour_class, input ready);
  modport sink (input valid, hue, saturation, brightness, colour_class, output ready);
endinterface

// Configuration write channel.
interface phc_cfg_if;
  import phc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RangeW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/phc_front.sv
module phc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [phc_pkg::PixW-1:0] red_i,
  input  logic [phc_pkg::PixW-1:0] green_i,
  input  logic [phc_pkg::PixW-1:0] blue_i,
  input  logic                     masked_i,
  output logic                     valid_o,
  output phc_pkg::div_t            data_o
);
  import phc_pkg::*;

  logic [PixW-1:0]    mx, mn, delta, abs_diff;
  logic signed [PixW:0] diff;
  hue_base_e          base;
  logic               valid_q;
  div_t               data_d, data_q;

  // Max, min and the signed difference that the hue formula needs.
  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    if (red_i == mx) begin
      base = HueBaseRed;
      diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == mx) begin
      base = HueBaseGreen;
      diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      base = HueBaseBlue;
      diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    abs_diff = diff[PixW] ? PixW'(-diff) : diff[PixW-1:0];
  end

  // Dividends: delta*255 and |diff|*30, built from shifts.
  always_comb begin
    data_d.masked  = masked_i;
    data_d.mx      = mx;
    data_d.delta   = delta;
    data_d.base    = base;
    data_d.hue_neg = diff[PixW];
    data_d.sat_rem = {delta, 8'd0} - {8'd0, delta};
    data_d.sat_q   = '0;
    data_d.hue_rem = {abs_diff, 5'd0} - {4'd0, abs_diff, 1'b0};
    data_d.hue_q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/phc_div_stage.sv
module phc_div_stage #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  phc_pkg::div_t data_i,
  output logic          valid_o,
  output phc_pkg::div_t data_o
);
  import phc_pkg::*;

  logic [SatRemW-1:0] sat_sub;
  logic [HueRemW-1:0] hue_rem_nx;
  logic [HueQW-1:0]   hue_q_nx;
  logic               valid_q;
  div_t               data_d, data_q;

  // Saturation quotient: one restoring step for this bit.
  assign sat_sub = {{(SatRemW-PixW){1'b0}}, data_i.mx} << Bit;

  // Hue quotient stays below 32, so only its low bits take a step.
  if (Bit < HueQW) begin : g_hue
    logic [HueRemW-1:0] hue_sub;
    assign hue_sub = {{(HueRemW-PixW){1'b0}}, data_i.delta} << Bit;
    always_comb begin
      hue_rem_nx = data_i.hue_rem;
      hue_q_nx   = data_i.hue_q;
      if (data_i.hue_rem >= hue_sub) begin
        hue_rem_nx    = data_i.hue_rem - hue_sub;
        hue_q_nx[Bit] = 1'b1;
      end
    end
  end else begin : g_no_hue
    assign hue_rem_nx = data_i.hue_rem;
    assign hue_q_nx   = data_i.hue_q;
  end

  always_comb begin
    data_d         = data_i;
    data_d.hue_rem = hue_rem_nx;
    data_d.hue_q   = hue_q_nx;
    if (data_i.sat_rem >= sat_sub) begin
      data_d.sat_rem    = data_i.sat_rem - sat_sub;
      data_d.sat_q[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/phc_post.sv
module phc_post (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  phc_pkg::div_t              data_i,
  input  logic [phc_pkg::RangeW-1:0] ranges_i [phc_pkg::NumClasses],
  output logic                       valid_o,
  output logic [phc_pkg::PixW-1:0]   hue_o,
  output logic [phc_pkg::PixW-1:0]   sat_o,
  output logic [phc_pkg::PixW-1:0]   val_o,
  output logic [phc_pkg::ClassW-1:0] class_o
);
  import phc_pkg::*;

  logic [PixW-1:0] q, hue_raw, hue_fold;
  hsv_t            hsv_d, hsv_q;
  logic            hsv_valid_q, out_valid_q;
  colour_class_e   class_d, class_q;
  logic [PixW-1:0] hue_q2, sat_q2, val_q2;

  // Signed offset around the sector base; a negative hue wraps by 180.
  always_comb begin
    q = {{(PixW-HueQW){1'b0}}, data_i.hue_q};
    case (data_i.base)
      HueBaseRed:   hue_raw = (data_i.hue_neg && q != '0) ? HueWrap - q : q;
      HueBaseGreen: hue_raw = data_i.hue_neg ? HueGreenBase - q : HueGreenBase + q;
      HueBaseBlue:  hue_raw = data_i.hue_neg ? HueBlueBase - q : HueBlueBase + q;
      default:      hue_raw = '0;
    endcase
    if (data_i.delta == '0) hue_raw = '0;
  end

  // Fold hues above 160 into the small values.
  always_comb begin
    if (hue_raw <= HueFoldMax)    hue_fold = hue_raw;
    else if (hue_raw <= HueFoldA) hue_fold = HueFoldValA;
    else if (hue_raw <= HueFoldB) hue_fold = HueFoldValB;
    else                          hue_fold = HueFoldValC;
  end

  always_comb begin
    hsv_d.masked = data_i.masked;
    hsv_d.hue    = hue_fold;
    hsv_d.sat    = (data_i.mx == '0) ? '0 : data_i.sat_q;
    hsv_d.val    = data_i.mx;
  end

  // Ordered class tests; the first match wins.
  always_comb begin
    class_d = ClassNone;
    if (!hsv_q.masked) begin
      if (in_range(ranges_i[CfgLine], hsv_q.hue, hsv_q.sat, hsv_q.val)) begin
        class_d = ClassLine;
      end else if (in_range(ranges_i[CfgField], hsv_q.hue, hsv_q.sat, hsv_q.val)) begin
        class_d = ClassField;
      end else if (in_range(ranges_i[CfgObstacle], hsv_q.hue, hsv_q.sat, hsv_q.val)) begin
        class_d = ClassObstacle;
      end else if (in_range(ranges_i[CfgBall], hsv_q.hue, hsv_q.sat, hsv_q.val)) begin
        class_d = ClassBall;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      hsv_valid_q <= valid_i;
      out_valid_q <= hsv_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hsv_q   <= hsv_d;
      hue_q2  <= hsv_q.hue;
      sat_q2  <= hsv_q.sat;
      val_q2  <= hsv_q.val;
      class_q <= class_d;
    end
  end

  assign valid_o = out_valid_q;
  assign hue_o   = hue_q2;
  assign sat_o   = sat_q2;
  assign val_o   = val_q2;
  assign class_o = class_q;

endmodule

>>> design/pixel_hsv_range_classifier.sv
// An accepted pixel passes a front stage, eight divider stages with one
// quotient bit each, a hue finish stage and a class stage to its result.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken, so ready follows the result side.
// Reset clears every valid bit and sets all four range registers to the
// no-match pattern; data registers are not reset.
module pixel_hsv_range_classifier (
  input  logic    clk_i,
  input  logic    rst_ni,
  phc_pix_if.sink pix_i,
  phc_cfg_if.sink cfg_i,
  phc_res_if.source res_o
);
  import phc_pkg::*;

  logic              en;
  logic [RangeW-1:0] ranges_q [NumClasses];
  logic              div_valid [SatQW+1];
  div_t              div_data  [SatQW+1];

  // The pipeline moves whenever the output register is empty or being taken.
  assign en          = !res_o.valid || res_o.ready;
  assign pix_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // Range registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) begin
        ranges_q[i] <= RangeReset;
      end
    end else if (cfg_i.valid) begin
      ranges_q[cfg_i.index] <= cfg_i.data;
    end
  end

  phc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pix_i.valid),
    .red_i    (pix_i.red),
    .green_i  (pix_i.green),
    .blue_i   (pix_i.blue),
    .masked_i (pix_i.masked),
    .valid_o  (div_valid[0]),
    .data_o   (div_data[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < SatQW; k++) begin : g_div
    phc_div_stage #(.Bit(SatQW - 1 - k)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[k]),
      .data_i  (div_data[k]),
      .valid_o (div_valid[k+1]),
      .data_o  (div_data[k+1])
    );
  end

  phc_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_valid[SatQW]),
    .data_i   (div_data[SatQW]),
    .ranges_i (ranges_q),
    .valid_o  (res_o.valid),
    .hue_o    (res_o.hue),
    .sat_o    (res_o.saturation),
    .val_o    (res_o.brightness),
    .class_o  (res_o.colour_class)
  );

endmodule

>>> design/phc_checker.sv
`include "assert_macros.svh"

module phc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [phc_pkg::PixW-1:0]   hue_i,
  input logic [phc_pkg::PixW-1:0]   saturation_i,
  input logic [phc_pkg::PixW-1:0]   brightness_i,
  input logic [phc_pkg::ClassW-1:0] colour_class_i
);
  import phc_pkg::*;

  // Folded hue never exceeds 160.
  `PHC_ASSERT(a_hue_max, clk_i, rst_ni, res_valid_i |-> hue_i <= HueFoldMax)

  // Class codes stop at ball.
  `PHC_ASSERT(a_class_max, clk_i, rst_ni, res_valid_i |-> colour_class_i <= ClassBall)

  // A black pixel has no saturation and no hue.
  `PHC_ASSERT(a_black, clk_i, rst_ni,
              (res_valid_i && brightness_i == '0) |-> (saturation_i == '0 && hue_i == '0))

  // A result that is not taken stays put.
  `PHC_ASSERT_HOLD(a_hold, clk_i, rst_ni, res_valid_i && !res_ready_i,
                   ({res_valid_i, hue_i, saturation_i, brightness_i, colour_class_i}))

endmodule

bind pixel_hsv_range_classifier phc_checker u_phc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .hue_i          (res_o.hue),
  .saturation_i   (res_o.saturation),
  .brightness_i   (res_o.brightness),
  .colour_class_i (res_o.colour_class)
);
